@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ src/ktm_pkg.sv @@
// Package for the k-mer table matcher: widths, defaults, output kinds, base code.
// Depends on nothing.
package ktm_pkg;
  localparam int KEY_W = 62;
  localparam int ID_W = 10;
  localparam int KLEN_W = 5;
  localparam int NUM_W = 5;
  localparam int KIND_W = 2;
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_PROBE_LIMIT = 16;
  localparam int DEF_MATCH_DEPTH = 16;
  localparam int DEF_ID_COUNT = 1024;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 5'd21;
  localparam logic [KLEN_W-1:0] KLEN_MIN = 5'd17;

  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TABLE_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST_FULL = 2'd2;

  // 2-bit base code; bit 2 set means not a base
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] r;
    begin
      case (ch)
        8'h41, 8'h61: r = 3'd0;
        8'h43, 8'h63: r = 3'd1;
        8'h47, 8'h67: r = 3'd2;
        8'h54, 8'h74: r = 3'd3;
        default: r = 3'd4;
      endcase
      return r;
    end
  endfunction
endpackage

@@ src/kmer_table_match.sv @@
// k-mer table matcher: load mode inserts both strands, scan mode reports ids.
// Per transfer: a non-base or short run goes straight to finish; a scan hashes the key,
// probes the table and on a hit walks the id list before any result; a load hashes and
// probes both keys and gives a result only when a key finds no slot in its probe window.
// One item at a time; the hash pass, the single-port table and a held result set it.
// Reset: synchronous; clears run state and match list, then sweeps the valid bits one a cycle.
module kmer_table_match #(
  parameter int TABLE_DEPTH      = ktm_pkg::DEF_TABLE_DEPTH,
  parameter int PROBE_LIMIT      = ktm_pkg::DEF_PROBE_LIMIT,
  parameter int MATCH_LIST_DEPTH = ktm_pkg::DEF_MATCH_DEPTH,
  parameter int ID_COUNT         = ktm_pkg::DEF_ID_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [7:0]                 base_char,
  input  logic [ktm_pkg::ID_W-1:0]   target_id,
  input  logic                       last_base,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ktm_pkg::KIND_W-1:0] kind,
  output logic [ktm_pkg::ID_W-1:0]   match_id,
  output logic [ktm_pkg::NUM_W-1:0]  match_number
);
  import ktm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(PROBE_LIMIT + 1);
  localparam int MW = $clog2(MATCH_LIST_DEPTH + 1);
  localparam int SW = (MATCH_LIST_DEPTH > 1) ? $clog2(MATCH_LIST_DEPTH) : 1;
  localparam logic [ID_W:0] ID_MAX = (ID_W+1)'(ID_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_RD, S_CMP, S_SEEN, S_NEXT_KEY, S_OUT, S_FIN
  } state_t;

  state_t state;
  logic [KLEN_W-1:0] kmer_len;
  logic [KEY_W-1:0] fwd, rev, key;
  logic [4:0] run_len;
  logic [MW-1:0] seen_count;
  logic [ID_W-1:0] seen_ids [MATCH_LIST_DEPTH];
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [ID_W-1:0] id_mem [TABLE_DEPTH];
  logic vld_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] rd_key;
  logic [ID_W-1:0] rd_id;
  logic rd_vld;
  logic [AW-1:0] slot, clr_addr;
  logic [PW-1:0] probes;
  logic [SW-1:0] seen_idx;
  logic second, fail, is_scan, is_last, pend_rec;
  logic [ID_W-1:0] tid, found_id;
  logic hash_start, hash_done;
  logic [63:0] hash;

  ktm_hash u_hash (.clk, .rst, .start(hash_start), .key(key), .done(hash_done), .hash(hash));

  // rolling k-mer update, combinational on the held input
  logic [4:0] k_eff;
  logic [KEY_W-1:0] mask, fwd_n, rev_n;
  logic [2:0] code;
  logic [5:0] shamt;
  always_comb begin
    k_eff = (kmer_len < KLEN_MIN) ? KLEN_MIN : kmer_len;
    mask = KEY_W'(({64'd0, 1'b1} << {k_eff, 1'b0}) - 65'd1);
    code = base_code(base_char);
    shamt = 6'({k_eff - 5'd1, 1'b0});
    fwd_n = ((fwd << 2) | KEY_W'(code[1:0])) & mask;
    rev_n = ((rev & mask) >> 2) | (KEY_W'(2'd3 - code[1:0]) << shamt);
  end

  assign pready = 1'b1;
  assign prdata = {27'd0, kmer_len};
  assign in_ready = (state == S_IDLE);
  assign hash_start = (state == S_HASH) && !hash_done && (probes == '0) && !pend_rec;

  always_ff @(posedge clk) begin
    rd_key <= key_mem[slot];
    rd_id <= id_mem[slot];
    rd_vld <= vld_mem[slot];
    if (state == S_CLEAR) vld_mem[clr_addr] <= 1'b0;
    else if (state == S_CMP && !is_scan && !rd_vld) begin
      vld_mem[slot] <= 1'b1;
      key_mem[slot] <= key;
      id_mem[slot] <= tid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      kmer_len <= KLEN_RESET;
      fwd <= '0;
      rev <= '0;
      run_len <= '0;
      seen_count <= '0;
      out_valid <= 1'b0;
      pend_rec <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) kmer_len <= pwdata[KLEN_W-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          is_scan <= mode;
          is_last <= last_base;
          tid <= ({1'b0, target_id} >= ID_MAX) ? ID_MAX[ID_W-1:0] : target_id;
          second <= 1'b0;
          fail <= 1'b0;
          probes <= '0;
          pend_rec <= 1'b0;
          if (code[2]) begin
            fwd <= '0; rev <= '0; run_len <= '0;
            state <= S_FIN;
          end else begin
            fwd <= fwd_n;
            rev <= rev_n;
            key <= fwd_n;
            if (run_len != 5'd31) run_len <= run_len + 5'd1;
            state <= ((run_len == 5'd31 ? run_len : run_len + 5'd1) >= k_eff) ? S_HASH
                                                                                : S_FIN;
          end
        end
        S_HASH: if (hash_done) begin
          slot <= hash[AW-1:0];
          probes <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (!rd_vld) begin
            state <= is_scan ? S_FIN : S_NEXT_KEY;
          end else if (rd_key == key) begin
            if (is_scan) begin
              found_id <= rd_id;
              seen_idx <= '0;
              state <= S_SEEN;
            end else state <= S_NEXT_KEY;
          end else if (probes == PW'(PROBE_LIMIT - 1)) begin
            if (!is_scan) fail <= 1'b1;
            state <= is_scan ? S_FIN : S_NEXT_KEY;
          end else begin
            probes <= probes + 1'b1;
            slot <= slot + 1'b1;
            state <= S_RD;
          end
        end
        S_SEEN: begin
          // one list entry a cycle
          if ({1'b0, seen_idx} >= MW'(seen_count) || MW'(seen_idx) >= seen_count)
            state <= S_OUT;
          else if (seen_ids[seen_idx] == found_id) state <= S_FIN;
          else if (MW'(seen_idx) == MW'(MATCH_LIST_DEPTH - 1)) state <= S_OUT;
          else seen_idx <= seen_idx + 1'b1;
        end
        S_NEXT_KEY: begin
          if (!second) begin
            second <= 1'b0 | 1'b1;
            key <= rev;
            probes <= '0;
            state <= S_HASH;
          end else if (fail) state <= S_OUT;
          else state <= S_FIN;
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          if (!is_scan) begin
            kind <= KIND_TABLE_FULL;
            match_id <= tid;
            match_number <= '0;
          end else if (seen_count < MW'(MATCH_LIST_DEPTH)) begin
            seen_ids[seen_count[SW-1:0]] <= found_id;
            seen_count <= seen_count + 1'b1;
            kind <= KIND_MATCH;
            match_id <= found_id;
            match_number <= NUM_W'(seen_count + 1'b1);
          end else begin
            kind <= KIND_LIST_FULL;
            match_id <= found_id;
            match_number <= NUM_W'(seen_count);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (is_last) begin
            fwd <= '0; rev <= '0; run_len <= '0;
            seen_count <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/ktm_hash.sv @@
// Iterative 64-bit mixing hash: one shift-add or shift-xor step per cycle.
// Depends on ktm_pkg.
module ktm_hash (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ktm_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [63:0]               hash
);
  import ktm_pkg::*;

  logic [63:0] v;
  logic [2:0]  step;
  logic        busy;
  logic [63:0] v_next;

  always_comb begin
    case (step)
      3'd0: v_next = v ^ (v >> 24);
      3'd1: v_next = v + (v << 3) + (v << 8);
      3'd2: v_next = v ^ (v >> 14);
      3'd3: v_next = v + (v << 2) + (v << 4);
      3'd4: v_next = v ^ (v >> 28);
      3'd5: v_next = v + (v << 31);
      default: v_next = v;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start && !busy) begin
      v <= ~{2'b00, key} + ({2'b00, key} << 21);
      step <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      v <= v_next;
      if (step == 3'd5) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 3'd1;
    end
  end

  assign hash = v;
endmodule

@@ src/ktm_checker.sv @@
// Port-level checker for kmer_table_match, bound into every kmer_table_match instance.
// Depends on ktm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ktm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ktm_pkg::KIND_W-1:0] kind,
  input logic [ktm_pkg::NUM_W-1:0]  match_number
);
  import ktm_pkg::*;

  `CHK_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "ready after transfer")
  `CHK_IMPL(a_kind_ok, clk, rst, out_valid, kind <= KIND_LIST_FULL, "bad kind")
  `CHK_IMPL(a_full_num, clk, rst, out_valid && kind == KIND_TABLE_FULL, match_number == '0,
    "table-full number")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(kind),
    "result dropped")
endmodule

bind kmer_table_match ktm_checker u_ktm_checker (.clk, .rst, .in_valid, .in_ready,
  .out_valid, .out_ready, .kind, .match_number);

@@ tb/sv/tb_top.sv @@
// Self-checking bench for kmer_table_match: load/scan streams, APB length writes.
// Holds its own model of the rolling k-mers, the probed table and the read's id list.
// Depends on ktm_pkg and the kmer_table_match RTL.
`timescale 1ns / 1ps

module tb_top;
  import ktm_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int PROBES = DEF_PROBE_LIMIT;
  localparam int LIST_DEPTH = DEF_MATCH_DEPTH;
  localparam logic [1:0] KLEN_ADDR = 2'd0;
  localparam int TARGET_ITEMS = 1800;
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic       m;
    logic [7:0] ch;
    logic [9:0] tid;
    logic       lst;
  } base_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] k;
    logic [ID_W-1:0]   id;
    logic [NUM_W-1:0]  num;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic mode = 1'b0;
  logic [7:0] base_char = '0;
  logic [ID_W-1:0] target_id = '0;
  logic last_base = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0] match_id;
  logic [NUM_W-1:0] match_number;

  kmer_table_match DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [4:0]  klen_cfg = KLEN_RESET;
  logic [63:0] fwd_kmer = '0, rev_kmer = '0;
  int unsigned run_len = 0;
  logic [63:0] slot_key [DEPTH];
  logic        slot_used [DEPTH];
  logic [9:0]  slot_id [DEPTH];
  logic [9:0]  read_ids [LIST_DEPTH];
  int unsigned read_id_count = 0;

  base_item_t pending_bases[$];
  match_t     expected_matches[$];
  int unsigned err_count = 0;
  int unsigned pushed = 0;
  bit quiet = 0;

  // target sequences of the current phase
  logic [7:0] tgt_seq [64][64];
  int tgt_len [64];
  int tgt_count = 0;

  initial for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;

  function automatic logic [63:0] hash_key(logic [63:0] v);
    v = ~v + (v << 21);
    v = v ^ (v >> 24);
    v = v + (v << 3) + (v << 8);
    v = v ^ (v >> 14);
    v = v + (v << 2) + (v << 4);
    v = v ^ (v >> 28);
    v = v + (v << 31);
    return v;
  endfunction

  function automatic bit table_put(logic [63:0] key, logic [9:0] id);
    int s;
    s = int'(hash_key(key) % DEPTH);
    for (int p = 0; p < PROBES; p++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_key[s] = key;
        slot_id[s] = id;
        return 1'b1;
      end
      if (slot_key[s] == key) return 1'b1;
      s = (s + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  function automatic bit table_get(logic [63:0] key, output logic [9:0] id);
    int s;
    s = int'(hash_key(key) % DEPTH);
    id = '0;
    for (int p = 0; p < PROBES; p++) begin
      if (!slot_used[s]) return 1'b0;
      if (slot_key[s] == key) begin
        id = slot_id[s];
        return 1'b1;
      end
      s = (s + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  // one accepted transfer through the model
  task automatic roll_and_lookup(base_item_t it);
    int unsigned k;
    logic [63:0] mask, c;
    int code;
    logic [9:0] id;
    bit seen, ok1, ok2;
    match_t r;
    k = (klen_cfg < KLEN_MIN) ? KLEN_MIN : klen_cfg;
    mask = (64'd1 << (2 * k)) - 64'd1;
    case (it.ch)
      "A", "a": code = 0;
      "C", "c": code = 1;
      "G", "g": code = 2;
      "T", "t": code = 3;
      default:  code = 4;
    endcase
    if (code < 4) begin
      c = 64'(code);
      fwd_kmer = ((fwd_kmer << 2) | c) & mask;
      rev_kmer = ((rev_kmer & mask) >> 2) | ((64'd3 - c) << ((k - 1) * 2));
      if (run_len < 31) run_len++;
      if (run_len >= k) begin
        if (!it.m) begin
          ok1 = table_put(fwd_kmer, it.tid);
          ok2 = table_put(rev_kmer, it.tid);
          if (!ok1 || !ok2) begin
            r.k = KIND_TABLE_FULL; r.id = it.tid; r.num = '0;
            expected_matches.push_back(r);
          end
        end else if (table_get(fwd_kmer, id)) begin
          seen = 0;
          for (int j = 0; j < read_id_count; j++) if (read_ids[j] == id) seen = 1;
          if (!seen) begin
            if (read_id_count < LIST_DEPTH) begin
              read_ids[read_id_count] = id;
              read_id_count++;
              r.k = KIND_MATCH;
            end else begin
              r.k = KIND_LIST_FULL;
            end
            r.id = id;
            r.num = NUM_W'(read_id_count);
            expected_matches.push_back(r);
          end
        end
      end
    end else begin
      fwd_kmer = '0; rev_kmer = '0; run_len = 0;
    end
    if (it.lst) begin
      fwd_kmer = '0; rev_kmer = '0; run_len = 0;
      read_id_count = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    base_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) roll_and_lookup('{mode, base_char, target_id, last_base});
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_bases.size() != 0) begin
        it = pending_bases.pop_front();
        mode <= it.m; base_char <= it.ch; target_id <= it.tid; last_base <= it.lst;
        nv = 1'b1;
        in_gap <= pick_gap();
        if ($urandom_range(0, 199) == 0) quiet = !quiet;
      end
      in_valid <= nv;
    end
  end

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    match_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        flag_mismatch("unexpected result kind", kind, -1);
      end else begin
        e = expected_matches.pop_front();
        if (kind != e.k) flag_mismatch("kind", kind, e.k);
        if (match_id != e.id) flag_mismatch("match_id", match_id, e.id);
        if (match_number != e.num) flag_mismatch("match_number", match_number, e.num);
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) out_gap <= pick_gap();
    end
  end

  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_base(logic m, logic [7:0] ch, logic [9:0] tid, logic lst);
    pending_bases.push_back('{m, ch, tid, lst});
    pushed++;
  endtask

  function automatic logic [7:0] rand_base();
    case ($urandom_range(0, 7))
      0: return "A"; 1: return "C"; 2: return "G"; 3: return "T";
      4: return "a"; 5: return "c"; 6: return "g";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] code_char(logic [1:0] c);
    case (c)
      2'd0: return "A"; 2'd1: return "C"; 2'd2: return "G";
      default: return "T";
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] ch;
    ch = 8'($urandom);
    if (ch inside {"A", "C", "G", "T", "a", "c", "g", "t"}) ch = "N";
    return ch;
  endfunction

  function automatic int cur_k();
    return (klen_cfg < KLEN_MIN) ? KLEN_MIN : klen_cfg;
  endfunction

  task automatic send_target(int t, logic [9:0] id);
    for (int i = 0; i < tgt_len[t]; i++)
      push_base(1'b0, tgt_seq[t][i], id, i == tgt_len[t] - 1);
  endtask

  task automatic load_targets(int n, int lo, int hi);
    int t;
    for (int i = 0; i < n && tgt_count < 64; i++) begin
      t = tgt_count++;
      if (t > 0 && $urandom_range(0, 4) == 0) begin
        // same sequence again under another id: the earlier id must survive
        tgt_len[t] = tgt_len[t-1];
        for (int j = 0; j < tgt_len[t]; j++) tgt_seq[t][j] = tgt_seq[t-1][j];
      end else begin
        tgt_len[t] = $urandom_range(lo, hi);
        for (int j = 0; j < tgt_len[t]; j++) tgt_seq[t][j] = rand_base();
      end
      send_target(t, 10'($urandom));
    end
  endtask

  task automatic scan_read(int nseg, bit all_in_order);
    logic [7:0] rd[$];
    int t, off, ext, k;
    k = cur_k();
    for (int s = 0; s < nseg; s++) begin
      t = all_in_order ? s % tgt_count : $urandom_range(0, tgt_count - 1);
      off = $urandom_range(0, tgt_len[t] - k);
      ext = $urandom_range(0, 3);
      for (int j = off; j < tgt_len[t] && j < off + k + ext; j++) rd.push_back(tgt_seq[t][j]);
    end
    if ($urandom_range(0, 5) == 0) rd[$urandom_range(0, rd.size() - 1)] = noise_char();
    if ($urandom_range(0, 5) == 0) rd[$urandom_range(0, rd.size() - 1)] = rand_base();
    foreach (rd[i])
      push_base($urandom_range(0, 19) != 0 || all_in_order, rd[i], 10'($urandom),
                i == rd.size() - 1);
  endtask

  // keys whose forward hash lands on one slot, to overrun the probe window
  task automatic crowd_one_slot(int n);
    logic [63:0] key;
    int s;
    s = $urandom_range(0, DEPTH - 1);
    for (int i = 0; i < n; i++) begin
      do key = {$urandom, $urandom} & ((64'd1 << 34) - 1);
      while (int'(hash_key(key) % DEPTH) != s);
      for (int b = 16; b >= 0; b--)
        push_base(1'b0, code_char(key[2*b +: 2]), 10'($urandom), b == 0);
    end
  endtask

  task automatic wait_idle();
    while (pending_bases.size() != 0 || in_valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_klen(logic [4:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= KLEN_ADDR;
    pwdata <= {$urandom_range(0, 1) ? 27'h7FFFFFF : 27'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    klen_cfg = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic generic_phase();
    int k;
    k = cur_k();
    tgt_count = 0;
    load_targets(4, k, k + 25);
    for (int r = 0; r < 3; r++) scan_read($urandom_range(1, 4), 0);
    for (int i = 0; i < 6; i++)
      if ($urandom_range(0, 1)) push_base(1'($urandom), noise_char(), 10'($urandom), 0);
    // leave a run open so the next length write masks a live k-mer
    if ($urandom_range(0, 1))
      for (int i = 0; i < k + 2; i++) push_base(1'($urandom), rand_base(), 10'($urandom), 0);
  endtask

  initial begin
    logic [7:0] half[9];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset length 21
    push_base(1'b0, 8'h00, 10'h000, 1'b0);
    push_base(1'b1, 8'hFF, 10'h3FF, 1'b0);
    push_base(1'b0, 8'h80, 10'h155, 1'b1);
    push_base(1'b1, "N", 10'h2AA, 1'b0);
    tgt_count = 1;
    tgt_len[0] = 21;
    for (int j = 0; j < 21; j++) tgt_seq[0][j] = rand_base();
    send_target(0, 10'h3FF);
    send_target(0, 10'h000);
    for (int j = 0; j < 21; j++) push_base(1'b1, tgt_seq[0][j], 10'h000, j == 20);
    wait_idle();

    // shortest length: crowded slot, then a read hitting more ids than the list holds
    write_klen(5'd17);
    crowd_one_slot(18);
    tgt_count = 0;
    for (int t = 0; t < 18; t++) begin
      tgt_len[t] = 17;
      for (int j = 0; j < 17; j++) tgt_seq[t][j] = rand_base();
      send_target(t, 10'(t * 53 + 7));
      tgt_count++;
    end
    scan_read(18, 1);
    wait_idle();

    write_klen(5'd31);
    generic_phase();
    wait_idle();

    // below the legal range: behaves as 17
    write_klen(5'd0);
    generic_phase();
    wait_idle();

    // even length lets a k-mer equal its own reverse complement
    write_klen(5'd18);
    for (int j = 0; j < 9; j++) half[j] = code_char(2'($urandom));
    tgt_count = 1;
    tgt_len[0] = 18;
    for (int j = 0; j < 9; j++) begin
      tgt_seq[0][j] = half[j];
      case (half[8-j])
        "A": tgt_seq[0][9+j] = "T";
        "C": tgt_seq[0][9+j] = "G";
        "G": tgt_seq[0][9+j] = "C";
        default: tgt_seq[0][9+j] = "A";
      endcase
    end
    send_target(0, 10'($urandom));
    for (int j = 0; j < 18; j++) push_base(1'b1, tgt_seq[0][j], 10'h000, j == 17);
    generic_phase();
    wait_idle();

    while (pushed < TARGET_ITEMS) begin
      write_klen(5'($urandom_range(16, 31)));
      generic_phase();
      wait_idle();
    end

    if (err_count == 0 && expected_matches.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
